/* rtl/hks_pkg.sv */
// ----------------------------------------------------------------------------
// hks_pkg: shared types and constants of the HID keystroke sequencer
// Command codes, event layout and the controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package hks_pkg;

  // input command codes
  localparam logic [1:0] CMD_PUSH   = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_MOVE   = 2'd2;
  localparam logic [1:0] CMD_BUTTON = 2'd3;

  // report kinds
  localparam logic KIND_KEYBOARD = 1'b0;
  localparam logic KIND_MOUSE    = 1'b1;

  // poll interval after reset, in milliseconds
  localparam logic [7:0] POLL_INTERVAL_RST = 8'd10;

  // one queued key event
  typedef struct packed {
    logic [7:0]  mods;
    logic [7:0]  usage;
    logic [15:0] wait_ms;
  } event_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;  // a transaction is taken this cycle
    logic step;    // run one sequencer step
    logic load;    // event memory read data is valid
    logic mouse;   // emit the mouse report
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic poll_fire;      // this tick reaches the poll slot with the host ready
    logic need_read;      // sequencer is idle and the FIFO holds an event
    logic mouse_pending;  // a mouse report follows the keyboard step
  } dp_stat_t;

endpackage

/* rtl/hid_keystroke_sequencer.sv */
// ----------------------------------------------------------------------------
// hid_keystroke_sequencer: keyboard and mouse report sequencer
// Queues key events and emits HID keyboard and mouse reports on poll ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_cmd and its fields with start high; a transaction is taken at an
//   edge where start is high and busy is low. Push, motion and button
//   commands and ticks that do not reach a poll leave busy low.
//   A tick that polls with the host ready holds busy through the step state,
//   the load state for the registered read of the event memory when an event
//   is popped, and the mouse state for the mouse report.
//   Reports appear on out_* for exactly one cycle with out_valid high, at most
//   two per tick (keyboard first, then mouse), the last one flagged by
//   out_is_last; each is registered out of the step, load or mouse state. The
//   receiver cannot stall, so every report is taken in its one cycle.
//   cfg_poll_interval_ms is written through cfg_valid/cfg_ready while idle.
//   Reset empties the event FIFO, clears the sequencer and mouse state and
//   sets the poll interval to 10 ms.
// ----------------------------------------------------------------------------
module hid_keystroke_sequencer #(
  parameter int FIFO_DEPTH = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_cmd,
  input  logic [7:0]        in_mod_bits,
  input  logic [7:0]        in_usage_code,
  input  logic [15:0]       in_wait_ms,
  input  logic signed [7:0] in_move_x,
  input  logic signed [7:0] in_move_y,
  input  logic [7:0]        in_button_bits,
  input  logic              in_host_ready,
  output logic              out_valid,
  output logic              out_report_kind,
  output logic [7:0]        out_mods,
  output logic [7:0]        out_usage,
  output logic [7:0]        out_buttons,
  output logic signed [7:0] out_dx,
  output logic signed [7:0] out_dy,
  output logic              out_is_last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_poll_interval_ms
);

  hks_pkg::ctrl_cmd_t ctrl_cmd;
  hks_pkg::dp_stat_t  dp_stat;

  // take configuration only between transactions
  assign cfg_ready = !busy;

  hks_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .stat   (dp_stat),
    .cmd    (ctrl_cmd),
    .busy   (busy)
  );

  hks_datapath #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (ctrl_cmd),
    .stat            (dp_stat),
    .in_cmd          (in_cmd),
    .in_mod_bits     (in_mod_bits),
    .in_usage_code   (in_usage_code),
    .in_wait_ms      (in_wait_ms),
    .in_move_x       (in_move_x),
    .in_move_y       (in_move_y),
    .in_button_bits  (in_button_bits),
    .in_host_ready   (in_host_ready),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_data        (cfg_poll_interval_ms),
    .out_valid       (out_valid),
    .out_report_kind (out_report_kind),
    .out_mods        (out_mods),
    .out_usage       (out_usage),
    .out_buttons     (out_buttons),
    .out_dx          (out_dx),
    .out_dy          (out_dy),
    .out_is_last     (out_is_last)
  );

`ifndef SYNTH
  // a non-tick transaction leaves the report channel quiet next cycle
  a_quiet_after_nontick: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd != hks_pkg::CMD_TICK) |=> !out_valid)
    else $error("report after a non-tick transaction");

  // a report that is not last is followed at once by the mouse report
  a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_last) |=> (out_valid && out_report_kind == hks_pkg::KIND_MOUSE))
    else $error("report sequence broken");

  // keyboard reports carry no mouse content
  a_kbd_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_report_kind == hks_pkg::KIND_KEYBOARD) |->
    (out_buttons == 8'd0 && out_dx == 8'sd0 && out_dy == 8'sd0))
    else $error("keyboard report carries mouse data");
`endif

endmodule

/* rtl/hks_ram.sv */
// ----------------------------------------------------------------------------
// hks_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module hks_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/hks_datapath.sv */
// ----------------------------------------------------------------------------
// hks_datapath: event FIFO, timers, mouse state and report registers
// Executes the commands of the controller and reports its status back.
// ----------------------------------------------------------------------------
module hks_datapath #(
  parameter int FIFO_DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  hks_pkg::ctrl_cmd_t cmd,
  output hks_pkg::dp_stat_t  stat,
  input  logic [1:0]         in_cmd,
  input  logic [7:0]         in_mod_bits,
  input  logic [7:0]         in_usage_code,
  input  logic [15:0]        in_wait_ms,
  input  logic signed [7:0]  in_move_x,
  input  logic signed [7:0]  in_move_y,
  input  logic [7:0]         in_button_bits,
  input  logic               in_host_ready,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_data,
  output logic               out_valid,
  output logic               out_report_kind,
  output logic [7:0]         out_mods,
  output logic [7:0]         out_usage,
  output logic [7:0]         out_buttons,
  output logic signed [7:0]  out_dx,
  output logic signed [7:0]  out_dy,
  output logic               out_is_last
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  // sequencer states
  localparam logic [1:0] SEQ_IDLE    = 2'd0;
  localparam logic [1:0] SEQ_PRESSED = 2'd1;
  localparam logic [1:0] SEQ_WAITING = 2'd2;

  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [1:0]           seq_r, seq_nxt;
  hks_pkg::event_t      cur_ev_r, cur_ev_nxt;
  logic [15:0]          elapsed_r, elapsed_nxt;
  logic [7:0]           poll_cnt_r, poll_cnt_nxt;
  logic [7:0]           interval_r, interval_nxt;
  logic signed [7:0]    mouse_x_r, mouse_x_nxt;
  logic signed [7:0]    mouse_y_r, mouse_y_nxt;
  logic [7:0]           mouse_btn_r, mouse_btn_nxt;
  logic                 mouse_chg_r, mouse_chg_nxt;

  logic                 valid_r, valid_nxt;
  logic                 kind_r, kind_nxt;
  logic [7:0]           mods_r, mods_nxt;
  logic [7:0]           usage_r, usage_nxt;
  logic [7:0]           btn_r, btn_nxt;
  logic signed [7:0]    dx_r, dx_nxt;
  logic signed [7:0]    dy_r, dy_nxt;
  logic                 last_r, last_nxt;

  logic [PTR_W-1:0]     wr_ptr_inc;
  logic [PTR_W-1:0]     rd_ptr_inc;
  logic                 fifo_full;
  logic                 fifo_empty;
  logic [7:0]           interval_eff;
  logic [7:0]           poll_cnt_inc;
  logic                 is_tick;
  logic                 ram_we;
  logic                 ram_re;
  hks_pkg::event_t      ram_wdata;
  hks_pkg::event_t      ram_rdata;
  logic                 pure_delay;

  // event memory
  hks_ram #(
    .WIDTH ($bits(hks_pkg::event_t)),
    .DEPTH (FIFO_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  // pointer arithmetic and status
  assign wr_ptr_inc   = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_inc   = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
  assign fifo_full    = (wr_ptr_inc == rd_ptr_r);
  assign fifo_empty   = (wr_ptr_r == rd_ptr_r);
  assign interval_eff = (interval_r == 8'd0) ? 8'd1 : interval_r;
  assign poll_cnt_inc = poll_cnt_r + 8'd1;
  assign is_tick      = (in_cmd == hks_pkg::CMD_TICK);
  assign pure_delay   = (ram_rdata.mods == 8'd0) && (ram_rdata.usage == 8'd0)
                        && (ram_rdata.wait_ms != 16'd0);

  assign stat.poll_fire     = is_tick && (poll_cnt_inc >= interval_eff) && in_host_ready;
  assign stat.need_read     = (seq_r == SEQ_IDLE) && !fifo_empty;
  assign stat.mouse_pending = mouse_chg_r || (mouse_x_r != 8'sd0) || (mouse_y_r != 8'sd0);

  assign ram_we          = cmd.accept && (in_cmd == hks_pkg::CMD_PUSH) && !fifo_full;
  assign ram_wdata.mods    = in_mod_bits;
  assign ram_wdata.usage   = in_usage_code;
  assign ram_wdata.wait_ms = in_wait_ms;
  assign ram_re          = cmd.step && stat.need_read;

  // next state
  always_comb begin
    wr_ptr_nxt    = wr_ptr_r;
    rd_ptr_nxt    = rd_ptr_r;
    seq_nxt       = seq_r;
    cur_ev_nxt    = cur_ev_r;
    elapsed_nxt   = elapsed_r;
    poll_cnt_nxt  = poll_cnt_r;
    interval_nxt  = interval_r;
    mouse_x_nxt   = mouse_x_r;
    mouse_y_nxt   = mouse_y_r;
    mouse_btn_nxt = mouse_btn_r;
    mouse_chg_nxt = mouse_chg_r;
    valid_nxt     = 1'b0;
    kind_nxt      = kind_r;
    mods_nxt      = mods_r;
    usage_nxt     = usage_r;
    btn_nxt       = btn_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    last_nxt      = last_r;

    // take the poll interval register
    if (cfg_we) begin
      interval_nxt = cfg_data;
    end

    // handle an accepted transaction
    if (cmd.accept) begin
      unique case (in_cmd)
        hks_pkg::CMD_PUSH: begin
          if (!fifo_full) begin
            wr_ptr_nxt = wr_ptr_inc;
          end
        end
        hks_pkg::CMD_TICK: begin
          if (seq_r == SEQ_WAITING && elapsed_r != 16'hFFFF) begin
            elapsed_nxt = elapsed_r + 16'd1;
          end
          poll_cnt_nxt = (poll_cnt_inc >= interval_eff) ? 8'd0 : poll_cnt_inc;
        end
        hks_pkg::CMD_MOVE: begin
          mouse_x_nxt   = in_move_x;
          mouse_y_nxt   = in_move_y;
          mouse_chg_nxt = 1'b1;
        end
        hks_pkg::CMD_BUTTON: begin
          mouse_btn_nxt = in_button_bits;
          mouse_chg_nxt = 1'b1;
        end
        default: ;
      endcase
    end

    // one sequencer step
    if (cmd.step) begin
      priority case (seq_r)
        SEQ_PRESSED: begin
          valid_nxt = 1'b1;
          kind_nxt  = hks_pkg::KIND_KEYBOARD;
          mods_nxt  = 8'd0;
          usage_nxt = 8'd0;
          btn_nxt   = 8'd0;
          dx_nxt    = 8'sd0;
          dy_nxt    = 8'sd0;
          last_nxt  = !stat.mouse_pending;
          if (cur_ev_r.wait_ms != 16'd0) begin
            seq_nxt     = SEQ_WAITING;
            elapsed_nxt = 16'd0;
          end else begin
            seq_nxt = SEQ_IDLE;
          end
        end
        SEQ_WAITING: begin
          if (elapsed_r >= cur_ev_r.wait_ms) begin
            seq_nxt = SEQ_IDLE;
          end
        end
        default: begin
          if (!fifo_empty) begin
            rd_ptr_nxt = rd_ptr_inc;
          end
        end
      endcase
    end

    // popped event arrives from memory
    if (cmd.load) begin
      cur_ev_nxt = ram_rdata;
      if (pure_delay) begin
        seq_nxt     = SEQ_WAITING;
        elapsed_nxt = 16'd0;
      end else begin
        seq_nxt   = SEQ_PRESSED;
        valid_nxt = 1'b1;
        kind_nxt  = hks_pkg::KIND_KEYBOARD;
        mods_nxt  = ram_rdata.mods;
        usage_nxt = ram_rdata.usage;
        btn_nxt   = 8'd0;
        dx_nxt    = 8'sd0;
        dy_nxt    = 8'sd0;
        last_nxt  = !stat.mouse_pending;
      end
    end

    // mouse report closes the step
    if (cmd.mouse) begin
      valid_nxt     = 1'b1;
      kind_nxt      = hks_pkg::KIND_MOUSE;
      mods_nxt      = 8'd0;
      usage_nxt     = 8'd0;
      btn_nxt       = mouse_btn_r;
      dx_nxt        = mouse_x_r;
      dy_nxt        = mouse_y_r;
      last_nxt      = 1'b1;
      mouse_chg_nxt = 1'b0;
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      seq_r       <= SEQ_IDLE;
      cur_ev_r    <= '0;
      elapsed_r   <= '0;
      poll_cnt_r  <= '0;
      interval_r  <= hks_pkg::POLL_INTERVAL_RST;
      mouse_x_r   <= '0;
      mouse_y_r   <= '0;
      mouse_btn_r <= '0;
      mouse_chg_r <= 1'b0;
      valid_r     <= 1'b0;
    end else begin
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      seq_r       <= seq_nxt;
      cur_ev_r    <= cur_ev_nxt;
      elapsed_r   <= elapsed_nxt;
      poll_cnt_r  <= poll_cnt_nxt;
      interval_r  <= interval_nxt;
      mouse_x_r   <= mouse_x_nxt;
      mouse_y_r   <= mouse_y_nxt;
      mouse_btn_r <= mouse_btn_nxt;
      mouse_chg_r <= mouse_chg_nxt;
      valid_r     <= valid_nxt;
    end
  end

  // report payload registers
  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    mods_r  <= mods_nxt;
    usage_r <= usage_nxt;
    btn_r   <= btn_nxt;
    dx_r    <= dx_nxt;
    dy_r    <= dy_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid       = valid_r;
  assign out_report_kind = kind_r;
  assign out_mods        = mods_r;
  assign out_usage       = usage_r;
  assign out_buttons     = btn_r;
  assign out_dx          = dx_r;
  assign out_dy          = dy_r;
  assign out_is_last     = last_r;

endmodule

/* rtl/hks_ctrl.sv */
// ----------------------------------------------------------------------------
// hks_ctrl: transaction controller of the HID keystroke sequencer
// Accepts transactions and walks a poll through step, load and mouse phases.
// ----------------------------------------------------------------------------
module hks_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         in_cmd,
  input  hks_pkg::dp_stat_t  stat,
  output hks_pkg::ctrl_cmd_t cmd,
  output logic               busy
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_STEP  = 2'd1;
  localparam logic [1:0] S_LOAD  = 2'd2;
  localparam logic [1:0] S_MOUSE = 2'd3;

  logic [1:0] state_r, state_nxt;

  // decode commands
  assign busy       = (state_r != S_IDLE);
  assign cmd.accept = start && (state_r == S_IDLE);
  assign cmd.step   = (state_r == S_STEP);
  assign cmd.load   = (state_r == S_LOAD);
  assign cmd.mouse  = (state_r == S_MOUSE);

  // advance the poll sequence
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.accept && (in_cmd == hks_pkg::CMD_TICK) && stat.poll_fire) begin
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        if (stat.need_read) begin
          state_nxt = S_LOAD;
        end else if (stat.mouse_pending) begin
          state_nxt = S_MOUSE;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_LOAD: begin
        state_nxt = stat.mouse_pending ? S_MOUSE : S_IDLE;
      end
      S_MOUSE: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* verif/hid_keystroke_sequencer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hid_keystroke_sequencer_tb: self-checking bench of the keystroke sequencer
// Sends push, tick, motion and button transactions over start/busy, keeps its
// own copy of the key FIFO, poll divider, key sequencer and mouse state, and
// checks every report against the oldest one predicted from that copy.
// ----------------------------------------------------------------------------
module hid_keystroke_sequencer_tb;

  localparam int RING_DEPTH  = 128;
  localparam int PTR_W       = $clog2(RING_DEPTH);
  localparam int CLK_HALF    = 6;
  localparam int SETTLE      = 8;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int MAX_SHOWN   = 10;
  localparam int PHASE_ITEMS = 50;

  typedef enum logic [1:0] {KEY_IDLE, KEY_DOWN, KEY_DELAY} key_state_t;

  // one input transaction, all fields as driven on the ports
  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  mods;
    logic [7:0]  usage;
    logic [15:0] wait_ms;
    logic [7:0]  move_x;
    logic [7:0]  move_y;
    logic [7:0]  buttons;
    logic        host_ready;
  } hid_cmd_t;

  // one HID report as seen on the out_* ports
  typedef struct packed {
    logic       kind;
    logic [7:0] mods;
    logic [7:0] usage;
    logic [7:0] buttons;
    logic [7:0] dx;
    logic [7:0] dy;
    logic       last;
  } hid_report_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [1:0]        in_cmd;
  logic [7:0]        in_mod_bits;
  logic [7:0]        in_usage_code;
  logic [15:0]       in_wait_ms;
  logic signed [7:0] in_move_x;
  logic signed [7:0] in_move_y;
  logic [7:0]        in_button_bits;
  logic              in_host_ready;
  logic              out_valid;
  logic              out_report_kind;
  logic [7:0]        out_mods;
  logic [7:0]        out_usage;
  logic [7:0]        out_buttons;
  logic signed [7:0] out_dx;
  logic signed [7:0] out_dy;
  logic              out_is_last;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [7:0]        cfg_poll_interval_ms;

  // predicted block state
  hks_pkg::event_t   key_fifo [RING_DEPTH];
  logic [PTR_W-1:0]  fifo_wr     = '0;
  logic [PTR_W-1:0]  fifo_rd     = '0;
  key_state_t        key_state   = KEY_IDLE;
  hks_pkg::event_t   held_event  = '0;
  logic [15:0]       wait_count  = '0;
  logic [7:0]        poll_div    = '0;
  logic [7:0]        motion_x    = '0;
  logic [7:0]        motion_y    = '0;
  logic [7:0]        button_map  = '0;
  logic              mouse_dirty = 1'b0;
  logic [7:0]        poll_period = hks_pkg::POLL_INTERVAL_RST;

  hid_report_t       pending_reports [$];
  int unsigned       mismatch_count = 0;
  int unsigned       cycle_count;
  bit                gaps_on = 1'b1;

  hid_keystroke_sequencer #(
    .FIFO_DEPTH(RING_DEPTH)
  ) uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_cmd               (in_cmd),
    .in_mod_bits          (in_mod_bits),
    .in_usage_code        (in_usage_code),
    .in_wait_ms           (in_wait_ms),
    .in_move_x            (in_move_x),
    .in_move_y            (in_move_y),
    .in_button_bits       (in_button_bits),
    .in_host_ready        (in_host_ready),
    .out_valid            (out_valid),
    .out_report_kind      (out_report_kind),
    .out_mods             (out_mods),
    .out_usage            (out_usage),
    .out_buttons          (out_buttons),
    .out_dx               (out_dx),
    .out_dy               (out_dy),
    .out_is_last          (out_is_last),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_poll_interval_ms (cfg_poll_interval_ms)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Advance the predicted state by one transaction and queue its reports
  function automatic void predict_reports(input hid_cmd_t c);
    hid_report_t rep [$];
    logic [7:0]  interval;
    if (c.cmd == hks_pkg::CMD_PUSH) begin
      // drop the event when the ring is full
      if (fifo_wr + 1'b1 != fifo_rd) begin
        key_fifo[fifo_wr] = {c.mods, c.usage, c.wait_ms};
        fifo_wr++;
      end
    end else if (c.cmd == hks_pkg::CMD_MOVE) begin
      motion_x    = c.move_x;
      motion_y    = c.move_y;
      mouse_dirty = 1'b1;
    end else if (c.cmd == hks_pkg::CMD_BUTTON) begin
      button_map  = c.buttons;
      mouse_dirty = 1'b1;
    end else begin
      // millisecond tick: count delay, then run the poll divider
      interval = (poll_period == 8'd0) ? 8'd1 : poll_period;
      if (key_state == KEY_DELAY && wait_count != 16'hFFFF)
        wait_count++;
      poll_div++;
      if (poll_div >= interval) begin
        poll_div = '0;
        if (c.host_ready) begin
          case (key_state)
            KEY_DOWN: begin
              rep.push_back({hks_pkg::KIND_KEYBOARD, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0});
              if (held_event.wait_ms != 16'd0) begin
                key_state  = KEY_DELAY;
                wait_count = '0;
              end else begin
                key_state = KEY_IDLE;
              end
            end
            KEY_DELAY: begin
              if (wait_count >= held_event.wait_ms)
                key_state = KEY_IDLE;
            end
            default: begin
              if (fifo_rd != fifo_wr) begin
                held_event = key_fifo[fifo_rd];
                fifo_rd++;
                // a pure delay emits nothing and goes straight to waiting
                if (held_event.mods == 8'd0 && held_event.usage == 8'd0 &&
                    held_event.wait_ms != 16'd0) begin
                  key_state  = KEY_DELAY;
                  wait_count = '0;
                end else begin
                  rep.push_back({hks_pkg::KIND_KEYBOARD, held_event.mods, held_event.usage,
                                 8'd0, 8'd0, 8'd0, 1'b0});
                  key_state = KEY_DOWN;
                end
              end
            end
          endcase
          if (mouse_dirty || motion_x != 8'd0 || motion_y != 8'd0) begin
            rep.push_back({hks_pkg::KIND_MOUSE, 8'd0, 8'd0, button_map, motion_x, motion_y,
                           1'b0});
            mouse_dirty = 1'b0;
          end
        end
      end
      if (rep.size() > 0)
        rep[rep.size() - 1].last = 1'b1;
      foreach (rep[i])
        pending_reports.push_back(rep[i]);
    end
  endfunction

  function automatic void flag_report_error(input string msg);
    if (mismatch_count < MAX_SHOWN)
      $display("%0t: %s", $realtime, msg);
    mismatch_count++;
  endfunction

  function automatic string report_text(input hid_report_t r);
    return $sformatf("kind=%0d mods=%h usage=%h buttons=%h dx=%0d dy=%0d last=%0d",
                     r.kind, r.mods, r.usage, r.buttons, $signed(r.dx), $signed(r.dy),
                     r.last);
  endfunction

  // Check each report, predict each accepted transaction, track the register
  always @(posedge clk) begin : report_monitor
    hid_cmd_t    seen;
    hid_report_t got;
    hid_report_t want;
    if (rst_n) begin
      if (out_valid) begin
        got = {out_report_kind, out_mods, out_usage, out_buttons, out_dx, out_dy,
               out_is_last};
        if (pending_reports.size() == 0) begin
          flag_report_error({"unexpected report: ", report_text(got)});
        end else begin
          want = pending_reports.pop_front();
          if (got !== want)
            flag_report_error({"report mismatch: expected ", report_text(want),
                               " got ", report_text(got)});
        end
      end
      if (start && !busy) begin
        seen = {in_cmd, in_mod_bits, in_usage_code, in_wait_ms, in_move_x, in_move_y,
                in_button_bits, in_host_ready};
        predict_reports(seen);
      end
      if (cfg_valid && cfg_ready)
        poll_period = cfg_poll_interval_ms;
    end
  end

  // Fill every field with noise so unused fields are shown to be ignored
  function automatic hid_cmd_t random_fields(input logic [1:0] cmd);
    logic [63:0] bits;
    hid_cmd_t    c;
    bits  = {$urandom, $urandom};
    c     = bits[$bits(hid_cmd_t)-1:0];
    c.cmd = cmd;
    return c;
  endfunction

  // Drive one transaction, with an occasional gap, and hold it until taken
  task automatic send_item(input hid_cmd_t c);
    if (gaps_on && $urandom_range(99) < 13) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    in_cmd         <= c.cmd;
    in_mod_bits    <= c.mods;
    in_usage_code  <= c.usage;
    in_wait_ms     <= c.wait_ms;
    in_move_x      <= c.move_x;
    in_move_y      <= c.move_y;
    in_button_bits <= c.buttons;
    in_host_ready  <= c.host_ready;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic push_key(input logic [7:0] mods, input logic [7:0] usage,
                          input logic [15:0] wait_ms);
    hid_cmd_t c;
    c         = random_fields(hks_pkg::CMD_PUSH);
    c.mods    = mods;
    c.usage   = usage;
    c.wait_ms = wait_ms;
    send_item(c);
  endtask

  task automatic send_tick(input logic host_ready);
    hid_cmd_t c;
    c            = random_fields(hks_pkg::CMD_TICK);
    c.host_ready = host_ready;
    send_item(c);
  endtask

  task automatic set_motion(input logic [7:0] x, input logic [7:0] y);
    hid_cmd_t c;
    c        = random_fields(hks_pkg::CMD_MOVE);
    c.move_x = x;
    c.move_y = y;
    send_item(c);
  endtask

  task automatic set_buttons(input logic [7:0] buttons);
    hid_cmd_t c;
    c         = random_fields(hks_pkg::CMD_BUTTON);
    c.buttons = buttons;
    send_item(c);
  endtask

  // Drop start, drain every predicted report and let the block settle
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_poll_interval(input logic [7:0] ms);
    wait_idle();
    cfg_valid            <= 1'b1;
    cfg_poll_interval_ms <= ms;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Reset interval of 10 ms: press on the 10th tick, release on the 20th
  task automatic test_reset_interval();
    push_key(8'h02, 8'h04, 16'd0);
    set_buttons(8'h01);
    repeat (20) send_tick(1'b1);
  endtask

  // All-zero event, pure delay, release then wait, host not ready, motion extremes
  task automatic test_key_cases();
    write_poll_interval(8'd1);
    push_key(8'h00, 8'h00, 16'd0);
    push_key(8'h00, 8'h00, 16'd3);
    push_key(8'hFF, 8'hFF, 16'd2);
    push_key(8'h01, 8'h00, 16'd1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    set_motion(8'h80, 8'h7F);
    send_tick(1'b1);
    set_motion(8'h00, 8'h00);
    set_buttons(8'hFF);
    repeat (4) send_tick(1'b1);
    send_tick(1'b0);
    repeat (5) send_tick(1'b1);
    set_motion(8'h7F, 8'h80);
    set_buttons(8'h00);
    send_tick(1'b1);
    set_motion(8'h00, 8'h00);
    repeat (3) send_tick(1'b1);
  endtask

  // Zero interval acts as one; the widest interval polls every 255th tick
  task automatic test_interval_extremes();
    write_poll_interval(8'd0);
    push_key(8'h20, 8'h1E, 16'd0);
    repeat (4) send_tick(1'b1);
    write_poll_interval(8'd255);
    push_key(8'h40, 8'h28, 16'd0);
    set_motion(8'h01, 8'hFF);
    repeat (256) send_tick(1'b1);
    set_motion(8'h00, 8'h00);
  endtask

  // Overfill the ring so pushes are dropped, then work off a few events
  task automatic test_fifo_full();
    write_poll_interval(8'd1);
    repeat (RING_DEPTH + 2)
      push_key(8'($urandom_range(255, 1)), 8'($urandom), 16'd0);
    repeat (6) send_tick(1'b1);
    push_key(8'h80, 8'h3A, 16'd0);
    repeat (3) send_tick(1'b1);
  endtask

  // Bursts of keys worked off by ticks, with mouse updates and some noise
  task automatic test_random_traffic();
    logic [7:0]  phase_interval [5] = '{8'd1, 8'd2, 8'd3, 8'd0, 8'd5};
    hid_cmd_t    c;
    int unsigned sent;
    int unsigned pick;
    int unsigned polls_per_tick;
    logic [7:0]  mods;
    logic [7:0]  usage;
    logic [15:0] wait_ms;
    foreach (phase_interval[p]) begin
      write_poll_interval(phase_interval[p]);
      // keep the third phase free of gaps
      gaps_on        = (p != 2);
      polls_per_tick = (phase_interval[p] == 8'd0) ? 1 : phase_interval[p];
      sent           = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(99) < 15) begin
          c = random_fields(2'($urandom_range(3)));
          if (c.cmd == hks_pkg::CMD_PUSH)
            c.wait_ms = 16'($urandom_range(40));
          send_item(c);
          sent++;
        end else begin
          repeat ($urandom_range(3, 1)) begin
            pick    = $urandom_range(99);
            mods    = 8'($urandom);
            usage   = 8'($urandom);
            wait_ms = '0;
            if (pick >= 55 && pick < 80) begin
              wait_ms = 16'($urandom_range(20, 1));
            end else if (pick >= 80 && pick < 92) begin
              mods    = '0;
              usage   = '0;
              wait_ms = 16'($urandom_range(20, 1));
            end else if (pick >= 92) begin
              mods  = '0;
              usage = '0;
            end
            push_key(mods, usage, wait_ms);
            sent++;
          end
          if ($urandom_range(99) < 30) begin
            if ($urandom_range(1))
              set_buttons(8'($urandom));
            else if ($urandom_range(99) < 40)
              set_motion(8'h00, 8'h00);
            else
              set_motion(8'($urandom), 8'($urandom));
            sent++;
          end
          repeat ($urandom_range(8, 2) * polls_per_tick) begin
            send_tick($urandom_range(99) < 85);
            sent++;
          end
        end
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_n                = 1'b0;
    start                = 1'b0;
    in_cmd               = hks_pkg::CMD_TICK;
    in_mod_bits          = '0;
    in_usage_code        = '0;
    in_wait_ms           = '0;
    in_move_x            = '0;
    in_move_y            = '0;
    in_button_bits       = '0;
    in_host_ready        = 1'b0;
    cfg_valid            = 1'b0;
    cfg_poll_interval_ms = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_interval();
    test_key_cases();
    test_interval_extremes();
    test_random_traffic();
    test_fifo_full();
    wait_idle();

    if (mismatch_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Stop a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

endmodule
